// ----- sv/bbpg_pkg.sv -----
// Shared types, constants and codes for the bouncing ball pattern generator.
package bbpg_pkg;

  localparam int FRAME_SIDE  = 64;
  localparam int COORD_W     = 6;
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int GAIN_DEPTH  = 1 << ADDR_W;
  localparam int LEVEL_W     = 16;
  localparam int QUEUE_DEPTH = 8;

  localparam int RADIUS_MAX  = 10;
  localparam int RADIUS_MIN  = 5;

  localparam logic signed [15:0] CENTRE_RESET  = 16'sd32;
  localparam logic signed [15:0] RADIUS_RESET  = 16'sd10;
  localparam logic [31:0]        FRAMES_RESET  = 32'd3;
  localparam logic signed [15:0] BG_RESET      = 16'sd1000;
  localparam logic signed [15:0] BALL_RESET    = 16'sd2000;
  localparam logic signed [15:0] OPEN_RESET    = 16'sd2000;
  localparam logic signed [15:0] CLOSED_RESET  = 16'sd100;

  // Division by unity gain (2^14 - 1) as multiply by ceil(2^45 / 16383).
  localparam int          UNITY_GAIN  = 16383;
  localparam int          RECIP_SHIFT = 45;
  localparam logic [63:0] RECIP_WIDE  =
    ((64'd1 << RECIP_SHIFT) + 64'(UNITY_GAIN - 1)) / 64'(UNITY_GAIN);
  localparam logic [31:0] RECIP_MUL   = RECIP_WIDE[31:0];

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_IGNORE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_BALL   = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_CLOSED = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BALL   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOSED = 3'd4;

  typedef struct packed {
    logic [31:0]        frames;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] radius;
  } ball_snap_t;

  typedef struct packed {
    logic                        is_load;
    logic                        is_pixel;
    logic [ADDR_W-1:0]           addr;
    logic signed [15:0]          gain;
    logic signed [LEVEL_W-1:0]   level;
    ball_snap_t                  snap;
  } queue_word_t;

endpackage

// ----- sv/bouncing_ball_pattern_with_gain_unit.sv -----
// Bouncing ball test-pattern generator with per-pixel gain, top level.
// Takes one word per clock and gives one result word per clock unless in_stall or
// out_stall is high. A word passes two front stages (ball state update and
// distance squares), then a queue of QUEUE_DEPTH words, then four back stages
// (gain RAM read, level times gain, multiply by the reciprocal of unity gain,
// saturate into the output register). in_stall rises once the queue and the
// front stages together hold QUEUE_DEPTH words, which happens only while
// out_stall holds the back end. The gain RAM has one write and one read port and
// is used once per word; it needs no clearing after reset, and configuration is
// taken on any cycle with cfg_write high and rst low.
module bouncing_ball_pattern_with_gain_unit #(
  parameter int QUEUE_DEPTH = bbpg_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       op,
  input  logic [bbpg_pkg::COORD_W-1:0]     pixel_row,
  input  logic [bbpg_pkg::COORD_W-1:0]     pixel_col,
  input  logic signed [15:0]               gain_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               pixel_value,
  output logic [31:0]                      frame_count,
  output logic signed [15:0]               ball_x,
  output logic signed [15:0]               ball_y,
  output logic [14:0]                      ball_radius,
  input  logic                             cfg_write,
  input  logic [bbpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);

  logic                  push;
  bbpg_pkg::queue_word_t push_word;
  logic                  pop;
  bbpg_pkg::queue_word_t head;
  logic                  empty;
  logic [CNT_W-1:0]      count;

  bbpg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .pixel_row  (pixel_row),
    .pixel_col  (pixel_col),
    .gain_value (gain_value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_count(count),
    .push       (push),
    .push_word  (push_word)
  );

  bbpg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(push_word),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .count    (count)
  );

  bbpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_value(pixel_value),
    .frame_count(frame_count),
    .ball_x     (ball_x),
    .ball_y     (ball_y),
    .ball_radius(ball_radius)
  );

endmodule

// ----- sv/bbpg_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bbpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bbpg_queue.sv -----
// Short queue of classified words between front and back.
module bbpg_queue #(
  parameter int DEPTH = bbpg_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bbpg_pkg::queue_word_t push_word,
  input  logic                  pop,
  output bbpg_pkg::queue_word_t head,
  output logic                  empty,
  output logic [CNT_W-1:0]      count
);

  bbpg_pkg::queue_word_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/bbpg_front.sv -----
// Front end: accept words, hold configuration and ball state, classify pixels.
module bbpg_front #(
  parameter int DEPTH = bbpg_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [bbpg_pkg::COORD_W-1:0]        pixel_row,
  input  logic [bbpg_pkg::COORD_W-1:0]        pixel_col,
  input  logic signed [15:0]                  gain_value,
  input  logic                                cfg_write,
  input  logic [bbpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic [CNT_W-1:0]                    queue_count,
  output logic                                push,
  output bbpg_pkg::queue_word_t               push_word
);

  localparam logic signed [17:0] SIDE_S = 18'(bbpg_pkg::FRAME_SIDE);

  bbpg_pkg::mode_t    mode;
  logic signed [15:0] bg_level;
  logic signed [15:0] ball_level;
  logic signed [15:0] open_level;
  logic signed [15:0] closed_level;

  logic signed [15:0] cx;
  logic signed [15:0] cy;
  logic signed [15:0] rad;
  logic               dir_x;
  logic               dir_y;
  logic               dir_r;
  logic [31:0]        frames;

  logic               accept;
  logic               is_adv;
  logic               is_pixel;
  logic               is_load;
  bbpg_pkg::op_t      opc;

  logic signed [15:0] rad_adj;
  logic signed [15:0] half;
  logic signed [17:0] half_s;
  logic               dir_x_next;
  logic               dir_y_next;
  logic               dir_r_next;
  logic signed [15:0] cx_next;
  logic signed [15:0] cy_next;
  logic signed [15:0] rad_next;
  logic [31:0]        frames_next;
  bbpg_pkg::ball_snap_t snap;

  logic signed [15:0] lvl_in;
  logic signed [15:0] lvl_out;

  logic                          f1_valid;
  logic                          f1_load;
  logic                          f1_pixel;
  logic [bbpg_pkg::ADDR_W-1:0]   f1_addr;
  logic signed [15:0]            f1_gain;
  logic signed [16:0]            f1_dx;
  logic signed [16:0]            f1_dy;
  logic signed [15:0]            f1_r;
  logic signed [15:0]            f1_lvl_in;
  logic signed [15:0]            f1_lvl_out;
  bbpg_pkg::ball_snap_t          f1_snap;

  logic                          f2_valid;
  logic                          f2_load;
  logic                          f2_pixel;
  logic [bbpg_pkg::ADDR_W-1:0]   f2_addr;
  logic signed [15:0]            f2_gain;
  logic signed [33:0]            f2_sq_x;
  logic signed [33:0]            f2_sq_y;
  logic signed [31:0]            f2_rsq;
  logic signed [15:0]            f2_lvl_in;
  logic signed [15:0]            f2_lvl_out;
  bbpg_pkg::ball_snap_t          f2_snap;

  logic signed [34:0]            dist_sq;
  logic                          in_disc;
  logic [CNT_W:0]                occupied;

  assign occupied = (CNT_W + 1)'(queue_count) + (CNT_W + 1)'(f1_valid)
                  + (CNT_W + 1)'(f2_valid);
  assign in_stall = (occupied >= (CNT_W + 1)'(DEPTH));
  assign accept   = in_valid && !in_stall;

  assign opc      = bbpg_pkg::op_t'(op);
  assign is_adv   = (opc == bbpg_pkg::OP_ADVANCE);
  assign is_pixel = (opc == bbpg_pkg::OP_PIXEL);
  assign is_load  = (opc == bbpg_pkg::OP_LOAD);

  // Bounce: flip each axis past an edge, offset by half the radius.
  always_comb begin
    rad_adj    = rad + $signed({15'd0, rad[15]});
    half       = rad_adj >>> 1;
    half_s     = 18'(half);
    dir_x_next = ((18'(cx) > SIDE_S - half_s) || (18'(cx) < half_s)) ? !dir_x : dir_x;
    dir_y_next = ((18'(cy) > SIDE_S - half_s) || (18'(cy) < half_s)) ? !dir_y : dir_y;
    if (rad < 16'(bbpg_pkg::RADIUS_MIN)) begin
      dir_r_next = 1'b0;
    end else if (rad > 16'(bbpg_pkg::RADIUS_MAX)) begin
      dir_r_next = 1'b1;
    end else begin
      dir_r_next = dir_r;
    end
    cx_next     = cx + (dir_x_next ? -16'sd1 : 16'sd1);
    cy_next     = cy + (dir_y_next ? -16'sd1 : 16'sd1);
    rad_next    = rad + (dir_r_next ? -16'sd1 : 16'sd1);
    frames_next = frames + 32'd1;
    if (is_adv) begin
      snap = '{frames: frames_next, x: cx_next, y: cy_next, radius: rad_next};
    end else begin
      snap = '{frames: frames, x: cx, y: cy, radius: rad};
    end
  end

  always_comb begin
    lvl_in  = '0;
    lvl_out = '0;
    if (is_pixel) begin
      case (mode)
        bbpg_pkg::MODE_BALL: begin
          lvl_in  = ball_level;
          lvl_out = bg_level;
        end
        bbpg_pkg::MODE_OPEN: begin
          lvl_in  = open_level;
          lvl_out = open_level;
        end
        bbpg_pkg::MODE_CLOSED: begin
          lvl_in  = closed_level;
          lvl_out = closed_level;
        end
        default: begin
          lvl_in  = '0;
          lvl_out = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bbpg_pkg::MODE_BALL;
      bg_level     <= bbpg_pkg::BG_RESET;
      ball_level   <= bbpg_pkg::BALL_RESET;
      open_level   <= bbpg_pkg::OPEN_RESET;
      closed_level <= bbpg_pkg::CLOSED_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bbpg_pkg::CFG_MODE:   mode         <= bbpg_pkg::mode_t'(cfg_data[1:0]);
        bbpg_pkg::CFG_BG:     bg_level     <= cfg_data;
        bbpg_pkg::CFG_BALL:   ball_level   <= cfg_data;
        bbpg_pkg::CFG_OPEN:   open_level   <= cfg_data;
        bbpg_pkg::CFG_CLOSED: closed_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx     <= bbpg_pkg::CENTRE_RESET;
      cy     <= bbpg_pkg::CENTRE_RESET;
      rad    <= bbpg_pkg::RADIUS_RESET;
      dir_x  <= 1'b0;
      dir_y  <= 1'b0;
      dir_r  <= 1'b0;
      frames <= bbpg_pkg::FRAMES_RESET;
    end else if (accept && is_adv) begin
      cx     <= cx_next;
      cy     <= cy_next;
      rad    <= rad_next;
      dir_x  <= dir_x_next;
      dir_y  <= dir_y_next;
      dir_r  <= dir_r_next;
      frames <= frames_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_load    <= is_load;
    f1_pixel   <= is_pixel;
    f1_addr    <= {pixel_row, pixel_col};
    f1_gain    <= gain_value;
    f1_dx      <= $signed({11'd0, pixel_col}) - 17'(cx);
    f1_dy      <= $signed({11'd0, pixel_row}) - 17'(cy);
    f1_r       <= rad;
    f1_lvl_in  <= lvl_in;
    f1_lvl_out <= lvl_out;
    f1_snap    <= snap;

    f2_load    <= f1_load;
    f2_pixel   <= f1_pixel;
    f2_addr    <= f1_addr;
    f2_gain    <= f1_gain;
    f2_sq_x    <= f1_dx * f1_dx;
    f2_sq_y    <= f1_dy * f1_dy;
    f2_rsq     <= f1_r * f1_r;
    f2_lvl_in  <= f1_lvl_in;
    f2_lvl_out <= f1_lvl_out;
    f2_snap    <= f1_snap;
  end

  assign dist_sq = 35'(f2_sq_x) + 35'(f2_sq_y);
  assign in_disc = (dist_sq < 35'(f2_rsq));
  assign push    = f2_valid;

  always_comb begin
    push_word.is_load  = f2_load;
    push_word.is_pixel = f2_pixel;
    push_word.addr     = f2_addr;
    push_word.gain     = f2_gain;
    push_word.level    = in_disc ? f2_lvl_in : f2_lvl_out;
    push_word.snap     = f2_snap;
  end

endmodule

// ----- sv/bbpg_back.sv -----
// Back end: gain table access, gain scaling, saturation and output register.
module bbpg_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bbpg_pkg::queue_word_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    pixel_value,
  output logic [31:0]           frame_count,
  output logic signed [15:0]    ball_x,
  output logic signed [15:0]    ball_y,
  output logic [14:0]           ball_radius
);

  localparam int QW = 63 - bbpg_pkg::RECIP_SHIFT;

  logic                  advance;
  logic                  s1_valid;
  bbpg_pkg::queue_word_t s1_word;
  logic signed [15:0]    ram_q;
  logic signed [15:0]    gain_eff;
  logic signed [31:0]    prod;

  logic                  s2_valid;
  logic                  s2_neg;
  logic [30:0]           s2_mag;
  bbpg_pkg::ball_snap_t  s2_snap;

  logic                  s3_valid;
  logic                  s3_neg;
  logic [62:0]           s3_scaled;
  bbpg_pkg::ball_snap_t  s3_snap;

  logic [QW-1:0]         quot;
  logic signed [15:0]    sat;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;

  bbpg_ram #(
    .WIDTH(16),
    .DEPTH(bbpg_pkg::GAIN_DEPTH)
  ) u_gain_ram (
    .clk  (clk),
    .we   (pop && head.is_load),
    .waddr(head.addr),
    .wdata(head.gain),
    .re   (pop),
    .raddr(head.addr),
    .rdata(ram_q)
  );

  assign gain_eff = s1_word.is_pixel ? ram_q : 16'sd0;
  assign prod     = s1_word.level * gain_eff;

  always_comb begin
    quot = s3_scaled[62 -: QW];
    if (!s3_neg) begin
      sat = (quot > QW'(32767)) ? 16'sd32767 : 16'(quot);
    end else begin
      sat = (quot > QW'(32768)) ? -16'sd32768 : 16'(-quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_word     <= head;
      s2_neg      <= prod[31];
      s2_mag      <= prod[31] ? 31'(-prod) : prod[30:0];
      s2_snap     <= s1_word.snap;
      s3_neg      <= s2_neg;
      s3_scaled   <= 63'(s2_mag) * 63'(bbpg_pkg::RECIP_MUL);
      s3_snap     <= s2_snap;
      pixel_value <= sat;
      frame_count <= s3_snap.frames;
      ball_x      <= s3_snap.x;
      ball_y      <= s3_snap.y;
      ball_radius <= s3_snap.radius[14:0];
    end
  end

endmodule

// ----- sv/bbpg_checker.sv -----
// Port-level checks for the pattern generator, bound to the top level.
module bbpg_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] pixel_value,
  input logic [31:0]        frame_count,
  input logic signed [15:0] ball_x,
  input logic signed [15:0] ball_y,
  input logic [14:0]        ball_radius
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_value) && $stable(frame_count)
      && $stable(ball_x) && $stable(ball_y) && $stable(ball_radius))
    else $error("output word changed while stalled");

  a_radius_swing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ball_radius >= 15'(bbpg_pkg::RADIUS_MIN - 1))
      && (ball_radius <= 15'(bbpg_pkg::RADIUS_MAX + 1)))
    else $error("ball radius left its swing");

endmodule

bind bouncing_ball_pattern_with_gain_unit bbpg_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_value(pixel_value),
  .frame_count(frame_count),
  .ball_x     (ball_x),
  .ball_y     (ball_y),
  .ball_radius(ball_radius)
);
